[hdl/pibr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pibr_pkg
// Shared widths, reset values, register codes and saturation helper for the
// particle integrator.
// ----------------------------------------------------------------------------
package pibr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CELL_BITS_DEF = 8;

    localparam int DATA_W    = 32;
    localparam int DENS_W    = 31;
    localparam int CELL_W    = 24;
    localparam int DT_W      = 17;
    localparam int SIZE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int WIDE_W    = 72;

    localparam logic [DT_W-1:0]   TIME_STEP_RST = 17'd655;
    localparam logic [SIZE_W-1:0] SIZE_RST      = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP = 2'd0,
        REG_SIZE_X    = 2'd1,
        REG_SIZE_Y    = 2'd2,
        REG_SIZE_Z    = 2'd3
    } cfg_reg_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > 72'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/pibr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pibr interfaces
// Particle input channel, result output channel and configuration write
// channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pibr_particle_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [30:0] mass_density;
    logic [23:0] old_cell;
    logic        last_particle;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               force_x, force_y, force_z, mass_density, old_cell, last_particle,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               force_x, force_y, force_z, mass_density, old_cell, last_particle,
        output ready
    );
endinterface

interface pibr_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_pos_x;
    logic [31:0] new_pos_y;
    logic [31:0] new_pos_z;
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;
    logic [23:0] new_cell;
    logic [23:0] new_cell_index;
    logic        zero_density;
    logic        last_out;

    modport source (
        output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, new_cell, new_cell_index, zero_density, last_out,
        input  ready
    );
    modport sink (
        input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, new_cell, new_cell_index, zero_density, last_out,
        output ready
    );
endinterface

interface pibr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/particle_integrate_bounce_rebin.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_integrate_bounce_rebin
// Integrates one particle a word, reflects it off the box walls and re-bins
// it into the cell grid.
// ----------------------------------------------------------------------------
// Channels: particle (sink) takes one particle word per cycle unless the
// pipeline holds, result (source) gives one word per particle in the same
// order, and cfg (sink) writes time_step, size_x, size_y and size_z by index;
// it is always ready and must only be used while no particle is in flight.
// Pipeline: input register, the bit-per-stage divider for force / density,
// then acceleration, products, sums, wall reflection, cell and output registers.
// Throughput: one particle per cycle while results are accepted. The whole
// pipeline advances together; while a result waits unaccepted the pipeline
// holds and particle.ready is low, and no word is lost or repeated.
// Reset: all valid bits clear, registers return to dt = 655 and a 16 cubed
// grid. Zero density sets zero_density and saturates nonzero-force acceleration.
// ----------------------------------------------------------------------------
module particle_integrate_bounce_rebin #(
    parameter int FRAC_BITS       = pibr_pkg::FRAC_BITS_DEF,
    parameter int CELL_COORD_BITS = pibr_pkg::CELL_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    pibr_particle_if.sink  particle,
    pibr_result_if.source  result,
    pibr_cfg_if.sink       cfg
);

    localparam int DW     = pibr_pkg::DATA_W;
    localparam int WW     = pibr_pkg::WIDE_W;
    localparam int DT_W   = pibr_pkg::DT_W;
    localparam int SW     = pibr_pkg::SIZE_W;
    localparam int DIV_W  = DW + FRAC_BITS;
    localparam int DT2_W  = 2 * DT_W - FRAC_BITS;
    localparam int VP_W   = DW + DT_W + 1;
    localparam int AP_W   = DW + DT2_W + 1;
    localparam int CB     = CELL_COORD_BITS;
    localparam int CW     = (CB > SW) ? CB : SW;
    localparam int NC_W   = CB + 2;
    localparam int CMP_W  = CB + 10;
    localparam int OC_W   = pibr_pkg::CELL_W + 3 * CB;
    localparam int PK_W   = pibr_pkg::CELL_W + 3 * CB;
    localparam int IDX_W  = CW + 18;

    localparam logic [DIV_W-1:0] Q_POS_MAX = DIV_W'(64'h7FFFFFFF);
    localparam logic [DIV_W-1:0] Q_NEG_MAX = DIV_W'(64'h80000000);

    typedef struct packed {
        logic [2:0][DW-1:0] p;
        logic [2:0][DW-1:0] v;
        logic [2:0]         f_neg;
        logic [2:0]         f_nz;
        logic               zero;
        logic [23:0]        old_cell;
        logic               last;
    } side_t;

    // ---------------- configuration ----------------
    logic [DT_W-1:0]      time_step_reg;
    logic [SW-1:0]        size_x_reg;
    logic [SW-1:0]        size_y_reg;
    logic [SW-1:0]        size_z_reg;
    logic [DT2_W-1:0]     dt2_reg;
    logic [2*SW-1:0]      sxy_reg;
    logic [2*DT_W-1:0]    dt_sq;
    logic [SW-1:0]        size_arr [3];

    assign cfg.ready = 1'b1;
    assign dt_sq     = time_step_reg * time_step_reg;
    assign size_arr[0] = size_x_reg;
    assign size_arr[1] = size_y_reg;
    assign size_arr[2] = size_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= pibr_pkg::TIME_STEP_RST;
            size_x_reg    <= pibr_pkg::SIZE_RST;
            size_y_reg    <= pibr_pkg::SIZE_RST;
            size_z_reg    <= pibr_pkg::SIZE_RST;
            dt2_reg       <= '0;
            sxy_reg       <= '0;
        end
        else
        begin
            dt2_reg <= dt_sq[2*DT_W-1:FRAC_BITS];
            sxy_reg <= size_x_reg * size_y_reg;
            if (cfg.valid)
            begin
                case (pibr_pkg::cfg_reg_t'(cfg.index))
                    pibr_pkg::REG_TIME_STEP: time_step_reg <= cfg.data;
                    pibr_pkg::REG_SIZE_X:    size_x_reg    <= cfg.data[SW-1:0];
                    pibr_pkg::REG_SIZE_Y:    size_y_reg    <= cfg.data[SW-1:0];
                    pibr_pkg::REG_SIZE_Z:    size_z_reg    <= cfg.data[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic o_valid_reg;

    assign en             = !o_valid_reg || result.ready;
    assign particle.ready = en;

    // ---------------- input stage ----------------
    side_t                      s0_side_reg;
    side_t                      s0_side_next;
    logic [2:0][DW-1:0]         s0_fabs_reg;
    logic [2:0][DW-1:0]         s0_fabs_next;
    logic [pibr_pkg::DENS_W-1:0] s0_dens_reg;
    logic                       s0_valid_reg;
    logic [2:0][DW-1:0]         in_f;

    assign in_f[0] = particle.force_x;
    assign in_f[1] = particle.force_y;
    assign in_f[2] = particle.force_z;

    always_comb
    begin
        s0_side_next.p[0]     = particle.pos_x;
        s0_side_next.p[1]     = particle.pos_y;
        s0_side_next.p[2]     = particle.pos_z;
        s0_side_next.v[0]     = particle.vel_x;
        s0_side_next.v[1]     = particle.vel_y;
        s0_side_next.v[2]     = particle.vel_z;
        s0_side_next.zero     = (particle.mass_density == '0);
        s0_side_next.old_cell = particle.old_cell;
        s0_side_next.last     = particle.last_particle;
        for (int k = 0; k < 3; k++)
        begin
            s0_side_next.f_neg[k] = in_f[k][DW-1];
            s0_side_next.f_nz[k]  = (in_f[k] != '0);
            s0_fabs_next[k]       = in_f[k][DW-1] ? (~in_f[k] + 1'b1) : in_f[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_side_reg <= s0_side_next;
            s0_fabs_reg <= s0_fabs_next;
            s0_dens_reg <= particle.mass_density;
        end
    end

    // ---------------- divider and side line ----------------
    logic [DIV_W-1:0] quo [3];
    side_t            side_reg [DIV_W];
    logic             vld_reg  [DIV_W];

    for (genvar k = 0; k < 3; k++) begin : g_div
        pibr_div #(
            .DIVIDEND_W (DIV_W),
            .DIVISOR_W  (pibr_pkg::DENS_W)
        ) u_div (
            .clk      (clk),
            .en       (en),
            .dividend ({s0_fabs_reg[k], {FRAC_BITS{1'b0}}}),
            .divisor  (s0_dens_reg),
            .quotient (quo[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s0_side_reg;
            for (int i = 1; i < DIV_W; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // ---------------- acceleration ----------------
    side_t                  a_side_reg;
    logic signed [DW-1:0]   a_acc_reg  [3];
    logic signed [DW-1:0]   a_acc_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (side_reg[DIV_W-1].zero)
            begin
                if (side_reg[DIV_W-1].f_neg[k])
                    a_acc_next[k] = 32'sh80000000;
                else if (side_reg[DIV_W-1].f_nz[k])
                    a_acc_next[k] = 32'sh7FFFFFFF;
                else
                    a_acc_next[k] = '0;
            end
            else if (side_reg[DIV_W-1].f_neg[k])
            begin
                if (quo[k] > Q_NEG_MAX)
                    a_acc_next[k] = 32'sh80000000;
                else
                    a_acc_next[k] = $signed(~quo[k][DW-1:0] + 1'b1);
            end
            else
            begin
                if (quo[k] > Q_POS_MAX)
                    a_acc_next[k] = 32'sh7FFFFFFF;
                else
                    a_acc_next[k] = $signed(quo[k][DW-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= side_reg[DIV_W-1];
            a_acc_reg  <= a_acc_next;
        end
    end

    // ---------------- products ----------------
    side_t                 m_side_reg;
    logic signed [VP_W-1:0] m_vdt_reg  [3];
    logic signed [VP_W-1:0] m_adt_reg  [3];
    logic signed [AP_W-1:0] m_adt2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg <= a_side_reg;
            for (int k = 0; k < 3; k++)
            begin
                m_vdt_reg[k]  <= $signed(a_side_reg.v[k]) * $signed({1'b0, time_step_reg});
                m_adt_reg[k]  <= a_acc_reg[k] * $signed({1'b0, time_step_reg});
                m_adt2_reg[k] <= a_acc_reg[k] * $signed({1'b0, dt2_reg});
            end
        end
    end

    // ---------------- sums ----------------
    side_t                s_side_reg;
    logic signed [DW-1:0] s_np_reg  [3];
    logic signed [DW-1:0] s_nv_reg  [3];
    logic signed [DW-1:0] s_np_next [3];
    logic signed [DW-1:0] s_nv_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s_np_next[k] = pibr_pkg::sat32(WW'($signed(m_side_reg.p[k]))
                                           + WW'(m_vdt_reg[k] >>> FRAC_BITS)
                                           + WW'(m_adt2_reg[k] >>> (FRAC_BITS + 1)));
            s_nv_next[k] = pibr_pkg::sat32(WW'($signed(m_side_reg.v[k]))
                                           + WW'(m_adt_reg[k] >>> (FRAC_BITS + 1)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_side_reg <= m_side_reg;
            s_np_reg   <= s_np_next;
            s_nv_reg   <= s_nv_next;
        end
    end

    // ---------------- wall reflection ----------------
    side_t                r_side_reg;
    logic signed [DW-1:0] r_np_reg  [3];
    logic signed [DW-1:0] r_nv_reg  [3];
    logic signed [DW-1:0] r_np_next [3];
    logic signed [DW-1:0] r_nv_next [3];

    always_comb
    begin
        logic signed [WW-1:0] wall;
        logic signed [WW-1:0] npw;
        logic signed [WW-1:0] nvw;
        for (int k = 0; k < 3; k++)
        begin
            wall = $signed(WW'(size_arr[k])) <<< FRAC_BITS;
            npw  = WW'(s_np_reg[k]);
            nvw  = WW'(s_nv_reg[k]);
            r_np_next[k] = s_np_reg[k];
            r_nv_next[k] = s_nv_reg[k];
            if (npw < 0)
            begin
                r_np_next[k] = pibr_pkg::sat32(-npw);
                r_nv_next[k] = pibr_pkg::sat32(-nvw);
            end
            else if (npw > wall)
            begin
                r_np_next[k] = pibr_pkg::sat32((wall <<< 1) - npw);
                r_nv_next[k] = pibr_pkg::sat32(-nvw);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_side_reg <= s_side_reg;
            r_np_reg   <= r_np_next;
            r_nv_reg   <= r_nv_next;
        end
    end

    // ---------------- cell step and clamp ----------------
    side_t                c_side_reg;
    logic signed [DW-1:0] c_np_reg   [3];
    logic signed [DW-1:0] c_nv_reg   [3];
    logic [CW-1:0]        c_cell_reg [3];
    logic [CW-1:0]        c_cell_next[3];
    logic [OC_W-1:0]      oc_wide;

    assign oc_wide = OC_W'(r_side_reg.old_cell);

    always_comb
    begin
        logic [CB-1:0]           oc;
        logic signed [WW-1:0]    start;
        logic signed [WW-1:0]    npw;
        logic signed [NC_W-1:0]  nc;
        logic signed [CMP_W-1:0] ncw;
        logic signed [CMP_W-1:0] lim;
        for (int k = 0; k < 3; k++)
        begin
            oc    = oc_wide[k*CB +: CB];
            start = $signed(WW'(oc)) <<< FRAC_BITS;
            npw   = WW'(r_np_reg[k]);
            nc    = $signed(NC_W'(oc));
            if (npw < start)
                nc = nc - 2'sd1;
            else if (npw >= start + ($signed(WW'(1)) <<< FRAC_BITS))
                nc = nc + 2'sd1;
            ncw = CMP_W'(nc);
            lim = $signed(CMP_W'(size_arr[k])) - 2'sd1;
            if (size_arr[k] == '0 || ncw < 0)
                c_cell_next[k] = '0;
            else if (ncw > lim)
                c_cell_next[k] = lim[CW-1:0];
            else
                c_cell_next[k] = ncw[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= r_side_reg;
            c_np_reg   <= r_np_reg;
            c_nv_reg   <= r_nv_reg;
            c_cell_reg <= c_cell_next;
        end
    end

    // ---------------- packing, index and output register ----------------
    logic [PK_W-1:0]        pk;
    logic [IDX_W-1:0]       idx;
    logic signed [DW-1:0]   o_np_reg [3];
    logic signed [DW-1:0]   o_nv_reg [3];
    logic [23:0]            o_cell_reg;
    logic [23:0]            o_idx_reg;
    logic                   o_zero_reg;
    logic                   o_last_reg;

    always_comb
    begin
        pk = '0;
        for (int k = 0; k < 3; k++)
            pk[k*CB +: CB] = c_cell_reg[k][CB-1:0];
    end

    assign idx = IDX_W'(c_cell_reg[0])
               + IDX_W'(c_cell_reg[1]) * IDX_W'(size_x_reg)
               + IDX_W'(c_cell_reg[2]) * IDX_W'(sxy_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_np_reg   <= c_np_reg;
            o_nv_reg   <= c_nv_reg;
            o_cell_reg <= pk[23:0];
            o_idx_reg  <= idx[23:0];
            o_zero_reg <= c_side_reg.zero;
            o_last_reg <= c_side_reg.last;
        end
    end

    // Valid bits travel alongside the data and advance on the same enable.
    logic a_valid_reg, m_valid_reg, s_valid_reg, r_valid_reg, c_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_W; i++)
                vld_reg[i] <= 1'b0;
            a_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            s_valid_reg  <= 1'b0;
            r_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= particle.valid;
            vld_reg[0]   <= s0_valid_reg;
            for (int i = 1; i < DIV_W; i++)
                vld_reg[i] <= vld_reg[i-1];
            a_valid_reg  <= vld_reg[DIV_W-1];
            m_valid_reg  <= a_valid_reg;
            s_valid_reg  <= m_valid_reg;
            r_valid_reg  <= s_valid_reg;
            c_valid_reg  <= r_valid_reg;
            o_valid_reg  <= c_valid_reg;
        end
    end

    assign result.valid          = o_valid_reg;
    assign result.new_pos_x      = o_np_reg[0];
    assign result.new_pos_y      = o_np_reg[1];
    assign result.new_pos_z      = o_np_reg[2];
    assign result.new_vel_x      = o_nv_reg[0];
    assign result.new_vel_y      = o_nv_reg[1];
    assign result.new_vel_z      = o_nv_reg[2];
    assign result.new_cell       = o_cell_reg;
    assign result.new_cell_index = o_idx_reg;
    assign result.zero_density   = o_zero_reg;
    assign result.last_out       = o_last_reg;

    // ---------------- assertions ----------------
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !particle.ready)
        else $error("input accepted while the output word is stalled");

    a_empty_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> particle.ready)
        else $error("input refused with an empty output register");

    a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && size_x_reg != '0 |-> c_cell_reg[0] < CW'(size_x_reg))
        else $error("x cell coordinate outside the grid after clamping");

endmodule
`default_nettype wire

[hdl/pibr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pibr_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module pibr_div #(
    parameter int DIVIDEND_W = 48,
    parameter int DIVISOR_W  = 31
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int ACC_W = DIVISOR_W + DIVIDEND_W;

    // Each accumulator holds the partial remainder on top and the remaining
    // dividend bits below, into which the quotient bits are shifted.
    logic [ACC_W-1:0]     acc_reg [DIVIDEND_W];
    logic [DIVISOR_W-1:0] den_reg [DIVIDEND_W];

    for (genvar i = 0; i < DIVIDEND_W; i++) begin : g_stage
        logic [ACC_W-1:0]     acc_in;
        logic [DIVISOR_W-1:0] den_in;
        logic [DIVISOR_W:0]   trial;
        logic [DIVISOR_W:0]   diff;
        logic [ACC_W-1:0]     acc_next;

        if (i == 0) begin : g_first
            assign acc_in = {{DIVISOR_W{1'b0}}, dividend};
            assign den_in = divisor;
        end
        else begin : g_rest
            assign acc_in = acc_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        always_comb
        begin
            trial = acc_in[ACC_W-1:DIVIDEND_W-1];
            diff  = trial - {1'b0, den_in};
            if (trial >= {1'b0, den_in})
                acc_next = {diff[DIVISOR_W-1:0], acc_in[DIVIDEND_W-2:0], 1'b1};
            else
                acc_next = {trial[DIVISOR_W-1:0], acc_in[DIVIDEND_W-2:0], 1'b0};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[i] <= acc_next;
                den_reg[i] <= den_in;
            end
        end
    end

    assign quotient = acc_reg[DIVIDEND_W-1][DIVIDEND_W-1:0];

endmodule
`default_nettype wire
